// ----- sv/pekee_pkg.sv -----
// Shared types and constants for the pad edge key event encoder.
`timescale 1ns / 1ps

package pekee_pkg;

    // Pad and key table geometry
    localparam int NUM_BUTTONS   = 16;
    localparam int KEY_BITS      = 9;
    localparam int MAP_A_BITS    = 63;
    localparam int MAP_B_BITS    = 63;
    localparam int MAP_C_BITS    = 18;
    localparam int GATE_BITS     = 16;
    localparam int TIME_BITS     = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 63;
    localparam int IDX_BITS      = $clog2(NUM_BUTTONS);

    localparam logic [GATE_BITS-1:0] GATE_RESET = GATE_BITS'(4000);

    // Configuration register indices
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_A = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_B = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAP_C = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GATE  = 2'd3;

    // Input function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_REOPEN = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // take the input transaction
        logic emit;   // move the lowest pending event into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pending_any;   // at least one mapped change still to emit
        logic pending_one;   // exactly one left
        logic out_free;      // output register can take an event this cycle
    } status_t;

endpackage

// ----- sv/pekee_dp.sv -----
// Datapath: configuration, gate, button history, pending events and output register.
`timescale 1ns / 1ps

module pekee_dp import pekee_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      func,
    input  logic [NUM_BUTTONS-1:0]    buttons,
    input  logic [TIME_BITS-1:0]      now_us,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [KEY_BITS-1:0]       key_code,
    output logic                      pressed,
    output logic                      last
);

    logic [MAP_A_BITS-1:0]  map_a_reg;
    logic [MAP_B_BITS-1:0]  map_b_reg;
    logic [MAP_C_BITS-1:0]  map_c_reg;
    logic [GATE_BITS-1:0]   gate_reg;
    logic [NUM_BUTTONS-1:0] prev_buttons_reg;
    logic [TIME_BITS-1:0]   last_time_reg;
    logic [NUM_BUTTONS-1:0] pending_reg;
    logic                   out_valid_reg;
    logic [KEY_BITS-1:0]    key_code_reg;
    logic                   pressed_reg;
    logic                   last_reg;

    logic [KEY_BITS-1:0]    codes [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] mapped;
    logic [NUM_BUTTONS-1:0] changed;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   gate_open;
    logic [NUM_BUTTONS-1:0] lowest;
    logic [NUM_BUTTONS-1:0] rest;
    logic [IDX_BITS-1:0]    sel_idx;

    // Key table unpacked from the three map registers
    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            codes[i]     = map_a_reg[i*KEY_BITS +: KEY_BITS];
            codes[i + 7] = map_b_reg[i*KEY_BITS +: KEY_BITS];
        end
        for (int i = 0; i < 2; i++)
            codes[i + 14] = map_c_reg[i*KEY_BITS +: KEY_BITS];
        for (int i = 0; i < NUM_BUTTONS; i++)
            mapped[i] = (codes[i] != '0);
    end

    // Poll gate: open when never sampled or enough time has passed (wrapping)
    assign elapsed   = now_us - last_time_reg;
    assign gate_open = (last_time_reg == '0) ||
                       (elapsed[TIME_BITS-1:GATE_BITS] != '0) ||
                       (elapsed[GATE_BITS-1:0] >= gate_reg);
    assign changed   = buttons ^ prev_buttons_reg;

    // Lowest pending button
    assign lowest = pending_reg & (~pending_reg + NUM_BUTTONS'(1));
    assign rest   = pending_reg & ~lowest;
    always_comb
    begin
        sel_idx = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
            if (lowest[i])
                sel_idx = IDX_BITS'(i);
    end

    assign status.pending_any = (pending_reg != '0);
    assign status.pending_one = (pending_reg != '0) && (rest == '0);
    assign status.out_free    = !out_valid_reg || !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_a_reg <= '0;
            map_b_reg <= '0;
            map_c_reg <= '0;
            gate_reg  <= GATE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAP_A: map_a_reg <= cfg_data[MAP_A_BITS-1:0];
                CFG_MAP_B: map_b_reg <= cfg_data[MAP_B_BITS-1:0];
                CFG_MAP_C: map_c_reg <= cfg_data[MAP_C_BITS-1:0];
                CFG_GATE:  gate_reg  <= cfg_data[GATE_BITS-1:0];
                default:   ;
            endcase
        end
    end

    // Button history, gate time and pending change set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_buttons_reg <= '0;
            last_time_reg    <= '0;
            pending_reg      <= '0;
        end
        else if (cmd.load)
        begin
            if (func == FUNC_REOPEN)
                last_time_reg <= '0;
            else if (gate_open)
            begin
                prev_buttons_reg <= buttons;
                last_time_reg    <= (now_us == '0) ? TIME_BITS'(1) : now_us;
                pending_reg      <= changed & mapped;
            end
        end
        else if (cmd.emit)
            pending_reg <= rest;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            key_code_reg <= codes[sel_idx];
            pressed_reg  <= prev_buttons_reg[sel_idx];
            last_reg     <= (rest == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign key_code  = key_code_reg;
    assign pressed   = pressed_reg;
    assign last      = last_reg;

    // Checks
    a_emit_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.pending_any)
        else $error("event emitted with nothing pending");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("event overwrote an untaken output");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.pending_one) |=> (pending_reg == '0) && last_reg)
        else $error("final event left changes pending");

    a_no_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.emit))
        else $error("load and emit in the same cycle");

endmodule

// ----- sv/pekee_ctrl.sv -----
// Controller: accepts one transaction, then walks its pending events.
`timescale 1ns / 1ps

module pekee_ctrl import pekee_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Commands
    assign in_stall = (state_reg != ST_IDLE);
    assign cmd.load = (state_reg == ST_IDLE) && in_valid;
    assign cmd.emit = (state_reg == ST_SCAN) && status.pending_any && status.out_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (!status.pending_any || (cmd.emit && status.pending_one))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Checks
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !status.pending_any)
        else $error("idle with events still pending");

endmodule

// ----- sv/pad_edge_key_event_encoder_unit.sv -----
// Top level of the pad edge key event encoder.
// The transaction is first loaded into the pending set; its lowest event is then registered at the output.
// Each transaction's N mapped changed buttons (0..16) leave the pending set as events,
//   the controller emitting one event per cycle while the output register is free.
// Output stall holds events; input is stalled until the last event is registered.
// Reset (rst_n, asynchronous): gate open, history clear, table unmapped, gate 4000 us.
`timescale 1ns / 1ps

module pad_edge_key_event_encoder_unit import pekee_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic [NUM_BUTTONS-1:0]    buttons,
    input  logic [TIME_BITS-1:0]      now_us,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [KEY_BITS-1:0]       key_code,
    output logic                      pressed,
    output logic                      last
);

    cmd_t    cmd;
    status_t status;

    pekee_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pekee_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .func      (func),
        .buttons   (buttons),
        .now_us    (now_us),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_code  (key_code),
        .pressed   (pressed),
        .last      (last)
    );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the pad edge key event encoder: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;
    import pekee_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 67;

    typedef struct packed {
        logic [KEY_BITS-1:0] code;
        logic                down;
        logic                tail;
    } key_event_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // DUT signals, all inputs known from time zero
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_MAP_A;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic                     func      = FUNC_SAMPLE;
    logic [NUM_BUTTONS-1:0]   buttons   = '0;
    logic [TIME_BITS-1:0]     now_us    = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [KEY_BITS-1:0]      key_code;
    logic                     pressed;
    logic                     last;

    // Shadow of the block's registers and history
    logic [MAP_A_BITS-1:0]    shadow_map_a = '0;
    logic [MAP_B_BITS-1:0]    shadow_map_b = '0;
    logic [MAP_C_BITS-1:0]    shadow_map_c = '0;
    logic [GATE_BITS-1:0]     shadow_gate  = GATE_RESET;
    logic [NUM_BUTTONS-1:0]   held_buttons = '0;
    logic [TIME_BITS-1:0]     gate_stamp   = '0;

    key_event_t  key_events_due[$];
    int          errors      = 0;
    int          cycles      = 0;
    int          burst_left  = 0;
    int          taken_items = 0;
    int          stall_left  = 0;
    stall_mode_t stall_mode  = STALL_NONE;
    logic [TIME_BITS-1:0] clock_us = '0;

    pad_edge_key_event_encoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .buttons   (buttons),
        .now_us    (now_us),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_code  (key_code),
        .pressed   (pressed),
        .last      (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("pad_edge_key_event_encoder_unit regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Key table lookup from the shadow registers
    function automatic logic [KEY_BITS-1:0] key_of_button(int idx);
        if (idx < 7)
            return shadow_map_a[idx*KEY_BITS +: KEY_BITS];
        else if (idx < 14)
            return shadow_map_b[(idx-7)*KEY_BITS +: KEY_BITS];
        else
            return shadow_map_c[(idx-14)*KEY_BITS +: KEY_BITS];
    endfunction

    // Predict the key events of one accepted transaction
    task automatic encode_transaction(logic f, logic [NUM_BUTTONS-1:0] btn,
                                      logic [TIME_BITS-1:0] t);
        logic [NUM_BUTTONS-1:0] flips;
        logic [TIME_BITS-1:0]   elapsed;
        key_event_t             ev;
        int                     b;
        int                     final_b;
        if (f == FUNC_REOPEN)
        begin
            gate_stamp = '0;
            taken_items++;
            return;
        end
        elapsed = t - gate_stamp;
        if (gate_stamp != '0 && elapsed < TIME_BITS'(shadow_gate))
            return;    // gate still closed, sample dropped
        flips        = btn ^ held_buttons;
        held_buttons = btn;
        gate_stamp   = (t != '0) ? t : TIME_BITS'(1);
        taken_items++;
        final_b = -1;
        for (b = 0; b < NUM_BUTTONS; b++)
            if (flips[b] && key_of_button(b) != '0)
                final_b = b;
        for (b = 0; b < NUM_BUTTONS; b++)
        begin
            if (flips[b] && key_of_button(b) != '0)
            begin
                ev.code = key_of_button(b);
                ev.down = btn[b];
                ev.tail = (b == final_b);
                key_events_due.push_back(ev);
            end
        end
    endtask

    // Send one transaction; bursts of random length with random gaps between
    task automatic send_item(logic f, logic [NUM_BUTTONS-1:0] btn, logic [TIME_BITS-1:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        func     <= f;
        buttons  <= btn;
        now_us   <= t;
        do @(posedge clk); while (in_stall);
        encode_transaction(f, btn, t);
        burst_left--;
    endtask

    // Hold off the sender until every expected event has arrived and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (key_events_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAP_A: shadow_map_a = data[MAP_A_BITS-1:0];
            CFG_MAP_B: shadow_map_b = data[MAP_B_BITS-1:0];
            CFG_MAP_C: shadow_map_c = data[MAP_C_BITS-1:0];
            CFG_GATE:  shadow_gate  = data[GATE_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Random key table contents: a mix of unmapped, extreme and ordinary codes
    function automatic logic [CFG_DATA_BITS-1:0] random_key_map(int slots);
        logic [CFG_DATA_BITS-1:0] packed_codes;
        logic [KEY_BITS-1:0]      code;
        int                       s;
        int                       roll;
        packed_codes = CFG_DATA_BITS'({$urandom, $urandom});
        if ($urandom_range(0, 4) == 0)
            return packed_codes;
        for (s = 0; s < slots; s++)
        begin
            roll = $urandom_range(0, 7);
            if (roll < 2)
                code = '0;
            else if (roll == 2)
                code = '1;
            else
                code = KEY_BITS'($urandom_range(1, 511));
            packed_codes[s*KEY_BITS +: KEY_BITS] = code;
        end
        return packed_codes;
    endfunction

    // Next button levels, shaped around the current history
    function automatic logic [NUM_BUTTONS-1:0] next_buttons();
        case ($urandom_range(0, 5))
            0:       return held_buttons ^ (NUM_BUTTONS'(1) << $urandom_range(0, 15));
            1:       return ~held_buttons;
            2:       return held_buttons;
            3:       return held_buttons ^ (NUM_BUTTONS'($urandom) & NUM_BUTTONS'($urandom));
            default: return NUM_BUTTONS'($urandom);
        endcase
    endfunction

    // Receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 150);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= stall_left[1] & stall_left[0];
        endcase
    end

    // Event checker
    always @(posedge clk)
    begin : check_events
        key_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (key_events_due.size() == 0)
                report_mismatch($sformatf("unexpected event code %0d pressed %0b last %0b",
                                          key_code, pressed, last));
            else
            begin
                want = key_events_due.pop_front();
                if (key_code !== want.code)
                    report_mismatch($sformatf("key_code %0d, want %0d", key_code, want.code));
                if (pressed !== want.down)
                    report_mismatch($sformatf("pressed %0b, want %0b (code %0d)",
                                              pressed, want.down, want.code));
                if (last !== want.tail)
                    report_mismatch($sformatf("last %0b, want %0b (code %0d)",
                                              last, want.tail, want.code));
            end
        end
    end

    // Reset table is all unmapped; also checks the reset gate and the time-zero stamp
    task automatic test_unmapped_after_reset();
        send_item(FUNC_SAMPLE, 16'hFFFF, 32'd0);
        send_item(FUNC_SAMPLE, 16'h0000, 32'd100);
        send_item(FUNC_SAMPLE, 16'h0000, 32'd4000);
        send_item(FUNC_SAMPLE, 16'h1234, 32'd4001);
        settle();
    endtask

    // Fully mapped table with extreme codes, open gate, maximum event bursts
    task automatic test_full_table_edges();
        write_reg(CFG_MAP_A, '1);
        write_reg(CFG_MAP_B, CFG_DATA_BITS'({9'h100, 9'h080, 9'h040, 9'h020,
                                             9'h010, 9'h008, 9'h001}));
        write_reg(CFG_MAP_C, CFG_DATA_BITS'({9'h002, 9'h004}));
        write_reg(CFG_GATE, '0);
        send_item(FUNC_SAMPLE, 16'hFFFF, 32'd10);
        send_item(FUNC_SAMPLE, 16'h0000, 32'd10);
        send_item(FUNC_SAMPLE, 16'hFFFF, 32'd10);
        send_item(FUNC_SAMPLE, 16'hFFFF, 32'd11);
        send_item(FUNC_SAMPLE, 16'h7FFE, 32'd12);
        send_item(FUNC_SAMPLE, 16'h5555, 32'd13);
        send_item(FUNC_SAMPLE, 16'hAAAA, 32'd14);
        settle();
        // middle buttons unmapped
        write_reg(CFG_MAP_B, '0);
        send_item(FUNC_SAMPLE, 16'h0000, 32'd15);
        settle();
    endtask

    // Widest gate across the time wrap, reopen, and a sample at time zero
    task automatic test_gate_wrap();
        write_reg(CFG_GATE, CFG_DATA_BITS'(16'hFFFF));
        send_item(FUNC_REOPEN, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(FUNC_SAMPLE, 16'h00FF, 32'hFFFF_FF00);
        send_item(FUNC_SAMPLE, 16'hFF00, 32'h0000_FDFF);
        send_item(FUNC_SAMPLE, 16'hFF00, 32'h0000_FEFE);
        send_item(FUNC_SAMPLE, 16'hFF00, 32'h0000_FEFF);
        send_item(FUNC_REOPEN, 16'h0000, 32'h0000_0000);
        send_item(FUNC_SAMPLE, 16'h0F0F, 32'h0000_FF00);
        send_item(FUNC_REOPEN, 16'h5A5A, 32'h8000_0001);
        send_item(FUNC_SAMPLE, 16'hF0F0, 32'd0);
        send_item(FUNC_SAMPLE, 16'h0000, 32'd65535);
        send_item(FUNC_SAMPLE, 16'h0000, 32'd65536);
        settle();
    endtask

    // Random traffic over several table and gate settings
    task automatic test_random_traffic();
        int                   phase;
        int                   pick;
        logic [GATE_BITS-1:0] gate_pick;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       gate_pick = '0;
                1:       gate_pick = GATE_BITS'(1);
                2:       gate_pick = GATE_RESET;
                3:       gate_pick = '1;
                4:       gate_pick = GATE_BITS'($urandom);
                default: gate_pick = GATE_BITS'($urandom_range(2, 50));
            endcase
            write_reg(CFG_MAP_A, random_key_map(7));
            write_reg(CFG_MAP_B, random_key_map(7));
            write_reg(CFG_MAP_C, random_key_map(2));
            write_reg(CFG_GATE,
                      CFG_DATA_BITS'({CFG_DATA_BITS'({$urandom, $urandom}) >> GATE_BITS,
                                      gate_pick}));
            taken_items = 0;
            while (taken_items < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    send_item(FUNC_REOPEN, NUM_BUTTONS'($urandom), TIME_BITS'($urandom));
                    continue;
                end
                if (pick < 14 && shadow_gate > 1)
                    clock_us += $urandom_range(0, shadow_gate - 1);    // too early
                else if (pick < 17)
                    clock_us = ($urandom_range(0, 1) == 0) ? '0 : TIME_BITS'($urandom);
                else if (pick < 27)
                    clock_us += TIME_BITS'(shadow_gate);               // exactly on time
                else
                    clock_us += TIME_BITS'(shadow_gate) + $urandom_range(0, 2000);
                send_item(FUNC_SAMPLE, next_buttons(), clock_us);
            end
            settle();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unmapped_after_reset();
        test_full_table_edges();
        test_gate_wrap();
        test_random_traffic();
        settle();
        if (errors == 0)
            $display("pad_edge_key_event_encoder_unit regression: pass");
        else
            $display("pad_edge_key_event_encoder_unit regression: fail");
        $finish;
    end

endmodule
